@@ rtl/core/rte_pkg.sv @@
// ----------------------------------------------------------------------------
// rte_pkg
// shared constants, codes and types of the rips triangle enumerator
// ----------------------------------------------------------------------------
package rte_pkg;

   // parameter defaults
   localparam int MAX_VERTICES_DEF  = 64;
   localparam int DISTANCE_BITS_DEF = 32;

   // fixed field widths
   localparam int VCOUNT_W    = 7;
   localparam int LIMIT_W     = 32;
   localparam int EDGE_IDX_W  = 11;
   localparam int RANK_OUT_W  = 11;
   localparam int MIN_VERTICES = 3;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;

   localparam logic [CSR_IDX_W-1:0] REG_VERTEX_COUNT   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_DIAMETER_LIMIT = CSR_IDX_W'(1);

   localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = VCOUNT_W'(3);
   localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = '1;

   // input action codes
   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_STEP = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_A,
      ST_MUL_B,
      ST_RANK,
      ST_RD_AB,
      ST_RD_AC,
      ST_RD_BC,
      ST_MAX_BC,
      ST_OUT
   } rte_state_type;

   typedef enum logic [1:0] {
      RD_AB,
      RD_AC,
      RD_BC
   } rte_rd_sel_type;

   typedef struct packed {
      logic [VCOUNT_W-1:0] vertex_count;
      logic [LIMIT_W-1:0]  diameter_limit;
   } rte_cfg_type;

   typedef struct packed {
      logic           accept;
      logic           load_wr;
      logic           capture;
      logic           mul_a;
      logic           mul_b;
      logic           rank;
      logic           rd_en;
      rte_rd_sel_type rd_sel;
      logic           max_init;
      logic           max_acc;
      logic           out_load;
   } rte_cmd_type;

   typedef struct packed {
      logic req_valid;
      logic req_step;
      logic out_free;
   } rte_sts_type;

endpackage

@@ rtl/core/rte_req_if.sv @@
// ----------------------------------------------------------------------------
// rte_req_if
// input channel: load and step items
// ----------------------------------------------------------------------------
interface rte_req_if
   import rte_pkg::*;
#(
   parameter int DISTANCE_BITS = DISTANCE_BITS_DEF
) ();
   logic                     valid;
   logic                     ready;
   logic                     action;
   logic [EDGE_IDX_W-1:0]    edge_index;
   logic [DISTANCE_BITS-1:0] distance;

   modport source (output valid, output action, output edge_index, output distance,
                   input ready);
   modport sink   (input valid, input action, input edge_index, input distance,
                   output ready);
endinterface

@@ rtl/core/rte_rsp_if.sv @@
// ----------------------------------------------------------------------------
// rte_rsp_if
// result channel: one triangle per step
// ----------------------------------------------------------------------------
interface rte_rsp_if
   import rte_pkg::*;
#(
   parameter int DISTANCE_BITS = DISTANCE_BITS_DEF
) ();
   logic                     valid;
   logic                     ready;
   logic [RANK_OUT_W-1:0]    rank_ab;
   logic [RANK_OUT_W-1:0]    rank_ac;
   logic [RANK_OUT_W-1:0]    rank_bc;
   logic [DISTANCE_BITS-1:0] triangle_weight;
   logic                     kept;
   logic                     last;

   modport source (output valid, output rank_ab, output rank_ac, output rank_bc,
                   output triangle_weight, output kept, output last, input ready);
   modport sink   (input valid, input rank_ab, input rank_ac, input rank_bc,
                   input triangle_weight, input kept, input last, output ready);
endinterface

@@ rtl/core/rips_triangle_enumerator.sv @@
// ----------------------------------------------------------------------------
// rips_triangle_enumerator
// edge distance store and lexicographic triangle walk with weight and filter
// ----------------------------------------------------------------------------
//
//  channel  direction  transfer carries
//  -------  ---------  -------------------------------------------------------
//  req      in         action, edge_index, distance (load or step)
//  rsp      out        rank_ab, rank_ac, rank_bc, triangle_weight, kept, last
//  csr      in/out     apb-style writes and reads of vertex_count, limit
//
//  a load gives no result
//  a step loads the result register after these steps in order: the
//    mul_a and mul_b passes of the shared row-base multiplier, a rank step, the
//    ab, ac and bc edge reads through the single read port of the store, one per
//    cycle, the compare of the last edge and the output state; no new transfer is
//    taken until the step has left the output state
//  a full result register holds the step in its output state until rsp drains
//  reset clears the triple to (0,1,2) and the registers to their defaults;
//    the edge store is not cleared
//
module rips_triangle_enumerator
   import rte_pkg::*;
#(
   parameter int MAX_VERTICES  = MAX_VERTICES_DEF,
   parameter int DISTANCE_BITS = DISTANCE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   rte_req_if.sink               req,
   rte_rsp_if.source             rsp,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);
   // width of an internal edge rank, used by the rank order check
   localparam int RANK_W = $clog2(MAX_VERTICES * (MAX_VERTICES - 1) / 2);

   rte_cfg_type cfg;
   rte_cmd_type cmd;
   rte_sts_type sts;

   // configuration registers
   rte_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // step sequencer, accepts only between steps
   rte_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   assign req.ready = cmd.accept;

   // triple walk, ranks, edge store, result register
   rte_datapath #(
      .MAX_VERTICES  (MAX_VERTICES),
      .DISTANCE_BITS (DISTANCE_BITS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .cfg                 (cfg),
      .req_valid           (req.valid),
      .req_action          (req.action),
      .req_edge_index      (req.edge_index),
      .req_distance        (req.distance),
      .rsp_ready           (rsp.ready),
      .rsp_valid           (rsp.valid),
      .rsp_rank_ab         (rsp.rank_ab),
      .rsp_rank_ac         (rsp.rank_ac),
      .rsp_rank_bc         (rsp.rank_bc),
      .rsp_triangle_weight (rsp.triangle_weight),
      .rsp_kept            (rsp.kept),
      .rsp_last            (rsp.last)
   );

`ifndef ASSERT_OFF
   // a load transfer never raises a result
   a_load_no_result: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready && (req.action == ACT_LOAD)) |=> !$rose(rsp.valid))
      else $error("result raised after a load transfer");

   // a step transfer makes the block busy
   a_step_busy: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready && (req.action == ACT_STEP)) |=> !req.ready)
      else $error("input still ready after a step transfer");

   // edge ranks of a triple come out in lexicographic order
   a_rank_order: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> ((RANK_W > RANK_OUT_W) ||
                     ((rsp.rank_ab < rsp.rank_ac) && (rsp.rank_ac < rsp.rank_bc))))
      else $error("edge ranks out of order");
`endif
endmodule

@@ rtl/core/rte_ram.sv @@
// ----------------------------------------------------------------------------
// rte_ram
// generic ram, one write port, one read port, registered read
// ----------------------------------------------------------------------------
module rte_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2016
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

@@ rtl/core/rte_csr.sv @@
// ----------------------------------------------------------------------------
// rte_csr
// apb-style configuration registers
// ----------------------------------------------------------------------------
module rte_csr
   import rte_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output rte_cfg_type           cfg
);
   logic [VCOUNT_W-1:0]  vertex_count_ff, vertex_count_in;
   logic [LIMIT_W-1:0]   limit_ff, limit_in;
   logic [CSR_IDX_W-1:0] reg_idx;
   logic                 wr_en;

   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_comb begin
      vertex_count_in = vertex_count_ff;
      limit_in        = limit_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_VERTEX_COUNT:   vertex_count_in = pwdata[VCOUNT_W-1:0];
            REG_DIAMETER_LIMIT: limit_in        = pwdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= VCOUNT_RESET;
         limit_ff        <= LIMIT_RESET;
      end else begin
         vertex_count_ff <= vertex_count_in;
         limit_ff        <= limit_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_VERTEX_COUNT:   prdata = CSR_DATA_W'(vertex_count_ff);
         REG_DIAMETER_LIMIT: prdata = CSR_DATA_W'(limit_ff);
         default:            prdata = '0;
      endcase
   end

   assign cfg.vertex_count   = vertex_count_ff;
   assign cfg.diameter_limit = limit_ff;
endmodule

@@ rtl/core/rte_ctrl.sv @@
// ----------------------------------------------------------------------------
// rte_ctrl
// sequencer for loads and steps: rank products, ab/ac/bc edge reads, result
// ----------------------------------------------------------------------------
module rte_ctrl
   import rte_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  rte_sts_type sts,
   output rte_cmd_type cmd
);
   rte_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (sts.req_valid && sts.req_step) state_in = ST_MUL_A;
         ST_MUL_A:  state_in = ST_MUL_B;
         ST_MUL_B:  state_in = ST_RANK;
         ST_RANK:   state_in = ST_RD_AB;
         ST_RD_AB:  state_in = ST_RD_AC;
         ST_RD_AC:  state_in = ST_RD_BC;
         ST_RD_BC:  state_in = ST_MAX_BC;
         ST_MAX_BC: state_in = ST_OUT;
         ST_OUT:    if (sts.out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.rd_sel = RD_AB;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.accept  = 1'b1;
            cmd.load_wr = sts.req_valid && !sts.req_step;
            cmd.capture = sts.req_valid && sts.req_step;
         end
         ST_MUL_A: cmd.mul_a = 1'b1;
         ST_MUL_B: cmd.mul_b = 1'b1;
         ST_RANK:  cmd.rank  = 1'b1;
         ST_RD_AB: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_AB;
         end
         ST_RD_AC: begin
            cmd.rd_en    = 1'b1;
            cmd.rd_sel   = RD_AC;
            cmd.max_init = 1'b1;
         end
         ST_RD_BC: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = RD_BC;
            cmd.max_acc = 1'b1;
         end
         ST_MAX_BC: cmd.max_acc  = 1'b1;
         ST_OUT:    cmd.out_load = sts.out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

@@ rtl/core/rte_datapath.sv @@
// ----------------------------------------------------------------------------
// rte_datapath
// triple registers, shared rank multiplier, edge store and result register
// ----------------------------------------------------------------------------
module rte_datapath
   import rte_pkg::*;
#(
   parameter int MAX_VERTICES  = MAX_VERTICES_DEF,
   parameter int DISTANCE_BITS = DISTANCE_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  rte_cmd_type              cmd,
   output rte_sts_type              sts,
   input  rte_cfg_type              cfg,
   input  logic                     req_valid,
   input  logic                     req_action,
   input  logic [EDGE_IDX_W-1:0]    req_edge_index,
   input  logic [DISTANCE_BITS-1:0] req_distance,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output logic [RANK_OUT_W-1:0]    rsp_rank_ab,
   output logic [RANK_OUT_W-1:0]    rsp_rank_ac,
   output logic [RANK_OUT_W-1:0]    rsp_rank_bc,
   output logic [DISTANCE_BITS-1:0] rsp_triangle_weight,
   output logic                     rsp_kept,
   output logic                     rsp_last
);
   localparam int DEPTH  = MAX_VERTICES * (MAX_VERTICES - 1) / 2;
   localparam int RANK_W = $clog2(DEPTH);
   localparam int VW     = $clog2(MAX_VERTICES);
   localparam int NW     = $clog2(MAX_VERTICES + 1);
   localparam int XW     = NW + 1;
   localparam int PW     = VW + XW;
   localparam int CMP_W  = (DISTANCE_BITS > LIMIT_W) ? DISTANCE_BITS : LIMIT_W;

   logic [VW-1:0] first_ff, second_ff, third_ff;
   logic [VW-1:0] first_in, second_in, third_in;
   logic [VW-1:0] wa_ff, wb_ff, wc_ff;
   logic          last_ff;
   logic [PW-1:0] prod_ff;
   logic [RANK_W-1:0] base_a_ff, rab_ff, rac_ff, rbc_ff;
   logic [DISTANCE_BITS-1:0] max_ff;
   logic                     rsp_valid_ff;
   logic [RANK_OUT_W-1:0]    out_ab_ff, out_ac_ff, out_bc_ff;
   logic [DISTANCE_BITS-1:0] out_weight_ff;
   logic                     out_kept_ff, out_last_ff;

   logic [NW-1:0] n_eff;
   logic [XW-1:0] n_x, a_x, b_x, c_x, sa_x, sb_x, sc_x;
   logic [XW-1:0] wa_x, wb_x, wc_x;
   logic          triple_ok;
   logic [VW-1:0] mul_v;
   logic [XW-1:0] factor;
   logic [PW-1:0] prod_in;
   logic [RANK_W-1:0] rd_addr, wr_addr;
   logic [DISTANCE_BITS-1:0] rd_data;
   logic          wr_en;

   // clamp of the vertex count to 3..max
   always_comb begin
      if (32'(cfg.vertex_count) > 32'(MAX_VERTICES)) begin
         n_eff = NW'(MAX_VERTICES);
      end else if (32'(cfg.vertex_count) < 32'(MIN_VERTICES)) begin
         n_eff = NW'(MIN_VERTICES);
      end else begin
         n_eff = NW'(cfg.vertex_count);
      end
   end

   assign n_x = XW'(n_eff);
   assign a_x = XW'(first_ff);
   assign b_x = XW'(second_ff);
   assign c_x = XW'(third_ff);
   assign triple_ok = (a_x < b_x) && (b_x < c_x) && (c_x < n_x);

   // a triple that does not fit the vertex count falls back to the first one
   assign sa_x = triple_ok ? a_x : XW'(0);
   assign sb_x = triple_ok ? b_x : XW'(1);
   assign sc_x = triple_ok ? c_x : XW'(2);

   assign wa_x = XW'(wa_ff);
   assign wb_x = XW'(wb_ff);
   assign wc_x = XW'(wc_ff);

   // row base of vertex v is v*(2n-v-1)/2, product always even
   assign mul_v   = cmd.mul_a ? wa_ff : wb_ff;
   assign factor  = (n_x << 1) - XW'(mul_v) - XW'(1);
   assign prod_in = PW'(mul_v) * PW'(factor);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         wa_ff   <= VW'(sa_x);
         wb_ff   <= VW'(sb_x);
         wc_ff   <= VW'(sc_x);
         last_ff <= (sa_x + XW'(3) == n_x) && (sb_x + XW'(2) == n_x) &&
                    (sc_x + XW'(1) == n_x);
      end
      if (cmd.mul_a || cmd.mul_b) begin
         prod_ff <= prod_in;
      end
      if (cmd.mul_b) begin
         base_a_ff <= RANK_W'(prod_ff >> 1);
      end
      if (cmd.rank) begin
         rab_ff <= base_a_ff + RANK_W'(wb_x - wa_x - XW'(1));
         rac_ff <= base_a_ff + RANK_W'(wc_x - wa_x - XW'(1));
         rbc_ff <= RANK_W'(prod_ff >> 1) + RANK_W'(wc_x - wb_x - XW'(1));
      end
      if (cmd.max_init) begin
         max_ff <= rd_data;
      end else if (cmd.max_acc && (rd_data > max_ff)) begin
         max_ff <= rd_data;
      end
      if (cmd.out_load) begin
         out_ab_ff     <= RANK_OUT_W'(rab_ff);
         out_ac_ff     <= RANK_OUT_W'(rac_ff);
         out_bc_ff     <= RANK_OUT_W'(rbc_ff);
         out_weight_ff <= max_ff;
         out_kept_ff   <= CMP_W'(max_ff) <= CMP_W'(cfg.diameter_limit);
         out_last_ff   <= last_ff;
      end
   end

   // lexicographic advance of the working triple, wrapping to (0,1,2) after the last
   always_comb begin
      first_in  = first_ff;
      second_in = second_ff;
      third_in  = third_ff;
      if (cmd.out_load) begin
         if (wc_x + XW'(1) < n_x) begin
            first_in  = wa_ff;
            second_in = wb_ff;
            third_in  = VW'(wc_x + XW'(1));
         end else if (wb_x + XW'(2) < n_x) begin
            first_in  = wa_ff;
            second_in = VW'(wb_x + XW'(1));
            third_in  = VW'(wb_x + XW'(2));
         end else if (wa_x + XW'(3) < n_x) begin
            first_in  = VW'(wa_x + XW'(1));
            second_in = VW'(wa_x + XW'(2));
            third_in  = VW'(wa_x + XW'(3));
         end else begin
            first_in  = VW'(0);
            second_in = VW'(1);
            third_in  = VW'(2);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff     <= VW'(0);
         second_ff    <= VW'(1);
         third_ff     <= VW'(2);
         rsp_valid_ff <= 1'b0;
      end else begin
         first_ff  <= first_in;
         second_ff <= second_in;
         third_ff  <= third_in;
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      case (cmd.rd_sel)
         RD_AB:   rd_addr = rab_ff;
         RD_AC:   rd_addr = rac_ff;
         RD_BC:   rd_addr = rbc_ff;
         default: rd_addr = rab_ff;
      endcase
   end

   // loads beyond the store are dropped
   assign wr_en   = cmd.load_wr && (32'(req_edge_index) < 32'(DEPTH));
   assign wr_addr = RANK_W'(req_edge_index);

   rte_ram #(
      .WIDTH (DISTANCE_BITS),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_distance),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign sts.req_valid = req_valid;
   assign sts.req_step  = (req_action == ACT_STEP);
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_rank_ab         = out_ab_ff;
   assign rsp_rank_ac         = out_ac_ff;
   assign rsp_rank_bc         = out_bc_ff;
   assign rsp_triangle_weight = out_weight_ff;
   assign rsp_kept            = out_kept_ff;
   assign rsp_last            = out_last_ff;
endmodule

@@ dv/rips_triangle_enumerator_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rips_triangle_enumerator_tb
// self-checking bench: edge loads and triangle steps against a local walk model
// ----------------------------------------------------------------------------
//  a small model class mirrors the edge store, the vertex triple and both
//  registers, predicts one triangle per accepted step and checks every rsp
//  transfer in order. stimulus: a short directed part, a climb of the vertex
//  count from 3 to 64 that reaches the highest edge ranks, then random phases
//  with random register settings. both channels idle at random, and once the
//  receiver holds off for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
module rips_triangle_enumerator_tb;
   import rte_pkg::*;

   localparam int EDGE_COUNT       = MAX_VERTICES_DEF * (MAX_VERTICES_DEF - 1) / 2;
   localparam int ITEM_TARGET      = 1400;
   localparam int SETTLE_CYCLES    = 20;
   localparam int HOLD_CYCLES      = 400;
   localparam int HOLD_AFTER_ITEMS = 900;
   localparam int WATCHDOG_LIMIT   = 4000;

   // one triangle as seen on the rsp channel
   typedef struct packed {
      logic [RANK_OUT_W-1:0]        rank_ab;
      logic [RANK_OUT_W-1:0]        rank_ac;
      logic [RANK_OUT_W-1:0]        rank_bc;
      logic [DISTANCE_BITS_DEF-1:0] triangle_weight;
      logic                         kept;
      logic                         last;
   } triangle_type;

   // mirror of the block: edge store, held triple and registers
   class triangle_walk_model;
      logic [DISTANCE_BITS_DEF-1:0] edge_len [EDGE_COUNT];
      bit                           edge_loaded [EDGE_COUNT];
      logic [VCOUNT_W-1:0]          vertex_count;
      logic [LIMIT_W-1:0]           diameter_limit;
      int unsigned                  va, vb, vc;
      triangle_type                 pending_triangles [$];
      int unsigned                  mismatches;

      function new();
         vertex_count   = VCOUNT_RESET;
         diameter_limit = LIMIT_RESET;
         va = 0;
         vb = 1;
         vc = 2;
         mismatches = 0;
         foreach (edge_loaded[i]) edge_loaded[i] = 1'b0;
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_VERTEX_COUNT:   vertex_count   = data[VCOUNT_W-1:0];
            REG_DIAMETER_LIMIT: diameter_limit = data[LIMIT_W-1:0];
            default: ;
         endcase
      endfunction

      // vertex count clamped to 3..64
      function int unsigned eff_n();
         if (vertex_count < MIN_VERTICES) return MIN_VERTICES;
         if (vertex_count > MAX_VERTICES_DEF) return MAX_VERTICES_DEF;
         return vertex_count;
      endfunction

      function int unsigned edge_rank(int unsigned i, int unsigned j, int unsigned n);
         return n * i - (i * (i + 1)) / 2 + j - i - 1;
      endfunction

      // triple the next step works on; a stale triple falls back to (0,1,2)
      function void active_triple(output int unsigned a, output int unsigned b,
                                  output int unsigned c);
         int unsigned n;
         n = eff_n();
         if (va < vb && vb < vc && vc < n) begin
            a = va;
            b = vb;
            c = vc;
         end else begin
            a = 0;
            b = 1;
            c = 2;
         end
      endfunction

      function void take_item(logic act, logic [EDGE_IDX_W-1:0] idx,
                              logic [DISTANCE_BITS_DEF-1:0] edge_length);
         int unsigned n, a, b, c;
         triangle_type t;
         if (act == ACT_LOAD) begin
            if (idx < EDGE_COUNT) begin
               edge_len[idx]    = edge_length;
               edge_loaded[idx] = 1'b1;
            end
            return;
         end
         n = eff_n();
         active_triple(a, b, c);
         t.rank_ab = RANK_OUT_W'(edge_rank(a, b, n));
         t.rank_ac = RANK_OUT_W'(edge_rank(a, c, n));
         t.rank_bc = RANK_OUT_W'(edge_rank(b, c, n));
         t.triangle_weight = edge_len[t.rank_ab];
         if (edge_len[t.rank_ac] > t.triangle_weight) t.triangle_weight = edge_len[t.rank_ac];
         if (edge_len[t.rank_bc] > t.triangle_weight) t.triangle_weight = edge_len[t.rank_bc];
         t.kept = (t.triangle_weight <= diameter_limit);
         t.last = (a == n - 3 && b == n - 2 && c == n - 1);
         pending_triangles = {pending_triangles, t};
         // lexicographic advance with wrap
         if (c + 1 < n) begin
            c = c + 1;
         end else if (b + 2 < n) begin
            b = b + 1;
            c = b + 1;
         end else if (a + 3 < n) begin
            a = a + 1;
            b = a + 1;
            c = a + 2;
         end else begin
            a = 0;
            b = 1;
            c = 2;
         end
         va = a;
         vb = b;
         vc = c;
      endfunction

      function void check_triangle(triangle_type got);
         triangle_type want;
         if (pending_triangles.size() == 0) begin
            flag($sformatf("unexpected triangle ab %0d ac %0d bc %0d w %h kept %b last %b",
                           got.rank_ab, got.rank_ac, got.rank_bc, got.triangle_weight,
                           got.kept, got.last));
            return;
         end
         want = pending_triangles.pop_front();
         if (got !== want)
            flag($sformatf({"triangle mismatch: expected ab %0d ac %0d bc %0d w %h kept %b",
                            " last %b, got ab %0d ac %0d bc %0d w %h kept %b last %b"},
                           want.rank_ab, want.rank_ac, want.rank_bc, want.triangle_weight,
                           want.kept, want.last, got.rank_ab, got.rank_ac, got.rank_bc,
                           got.triangle_weight, got.kept, got.last));
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   rte_req_if req_chan ();
   rte_rsp_if rsp_chan ();

   triangle_walk_model           walk;
   int unsigned                  items_accepted = 0;
   int unsigned                  quiet_cycles = 0;
   bit                           no_idle = 1'b0;     // burst stretch on both sides
   bit                           hold_done = 1'b0;
   logic [DISTANCE_BITS_DEF-1:0] recent_distance = '0;

   rips_triangle_enumerator u_top (
      .clock       (clock),
      .reset       (reset),
      .req         (req_chan),
      .rsp         (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // idle length: mostly none or short, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned r;
      if (no_idle) return 0;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // edge lengths lean on the extremes and on small values that tie
   function automatic logic [DISTANCE_BITS_DEF-1:0] pick_distance();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 12) recent_distance = '0;
      else if (r < 24) recent_distance = '1;
      else if (r < 34) recent_distance = DISTANCE_BITS_DEF'($urandom_range(15));
      else recent_distance = $urandom;
      return recent_distance;
   endfunction

   // limits at the extremes, random, or equal to a stored length
   function automatic logic [LIMIT_W-1:0] pick_limit();
      case ($urandom_range(4))
         0:       return '0;
         1:       return '1;
         2:       return recent_distance;
         3:       return LIMIT_W'($urandom_range(15));
         default: return $urandom;
      endcase
   endfunction

   // one req transfer; valid stays up when the next item follows at once
   task automatic send_item(input logic act, input logic [EDGE_IDX_W-1:0] idx,
                            input logic [DISTANCE_BITS_DEF-1:0] edge_length);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.action     <= act;
      req_chan.edge_index <= idx;
      req_chan.distance   <= edge_length;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
      walk.take_item(act, idx, edge_length);
      items_accepted++;
   endtask

   // drain every expected triangle, then let a possible load settle
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      while (walk.pending_triangles.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // apb setup and access; a read is checked against the mirrored register
   task automatic csr_access(input bit wr, input logic [CSR_IDX_W-1:0] idx,
                             input logic [CSR_DATA_W-1:0] data);
      logic [CSR_DATA_W-1:0] want;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (csr_pready !== 1'b1) @(posedge clock);
      if (wr) begin
         walk.write_reg(idx, data);
      end else begin
         want = (idx == REG_VERTEX_COUNT) ? CSR_DATA_W'(walk.vertex_count)
                                          : CSR_DATA_W'(walk.diameter_limit);
         if (csr_prdata !== want)
            walk.flag($sformatf("register %0d read: expected %h, got %h",
                                idx, want, csr_prdata));
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // only while idle; upper bits of the count word are junk that must be dropped
   task automatic set_config(input logic [VCOUNT_W-1:0] n_value,
                             input logic [LIMIT_W-1:0] limit_value);
      logic [CSR_DATA_W-1:0] n_word;
      wait_idle();
      n_word = $urandom;
      n_word[VCOUNT_W-1:0] = n_value;
      csr_access(1'b1, REG_VERTEX_COUNT, n_word);
      csr_access(1'b1, REG_DIAMETER_LIMIT, CSR_DATA_W'(limit_value));
      csr_access(1'b0, REG_VERTEX_COUNT, '0);
      csr_access(1'b0, REG_DIAMETER_LIMIT, '0);
   endtask

   // load whatever edges of the next triple are missing, maybe refresh some,
   // then step; the step's unused fields carry random bits
   task automatic step_triangle(input int unsigned rewrite_pct);
      int unsigned n, a, b, c;
      int unsigned r [3];
      n = walk.eff_n();
      walk.active_triple(a, b, c);
      r[0] = walk.edge_rank(a, b, n);
      r[1] = walk.edge_rank(a, c, n);
      r[2] = walk.edge_rank(b, c, n);
      foreach (r[k])
         if (!walk.edge_loaded[r[k]] || $urandom_range(99) < rewrite_pct)
            send_item(ACT_LOAD, EDGE_IDX_W'(r[k]), pick_distance());
      send_item(ACT_STEP, EDGE_IDX_W'($urandom), DISTANCE_BITS_DEF'($urandom));
   endtask

   // rsp ready: random runs, bursts with no stall, one long hold-off once the
   // sender is well into the random part so the block backs up into req
   initial begin : rsp_ready_drive
      int unsigned len;
      bit          level;
      forever begin
         if (!hold_done && items_accepted >= HOLD_AFTER_ITEMS) begin
            hold_done = 1'b1;
            level     = 1'b0;
            len       = HOLD_CYCLES;
         end else if (no_idle) begin
            level = 1'b1;
            len   = 1;
         end else if ($urandom_range(99) < 65) begin
            level = 1'b1;
            len   = $urandom_range(1, 12);
         end else begin
            level = 1'b0;
            len   = pick_gap() + 1;
         end
         rsp_chan.ready <= level;
         repeat (len) @(posedge clock);
      end
   end

   // every rsp transfer is checked against the oldest prediction
   always @(posedge clock) begin : triangle_monitor
      triangle_type got;
      if (reset === 1'b0 && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         got.rank_ab         = rsp_chan.rank_ab;
         got.rank_ac         = rsp_chan.rank_ac;
         got.rank_bc         = rsp_chan.rank_bc;
         got.triangle_weight = rsp_chan.triangle_weight;
         got.kept            = rsp_chan.kept;
         got.last            = rsp_chan.last;
         walk.check_triangle(got);
      end
   end

   // watchdog: too long without any transfer on req, rsp or csr
   always @(posedge clock) begin
      if ((req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
          (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) ||
          (csr_psel === 1'b1 && csr_penable === 1'b1)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL rips_triangle_enumerator");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int unsigned sel, phase_items;
      logic [VCOUNT_W-1:0] n_pick;
      walk = new();

      // every input known from time zero
      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.action     <= ACT_LOAD;
      req_chan.edge_index <= '0;
      req_chan.distance   <= '0;
      csr_psel            <= 1'b0;
      csr_penable         <= 1'b0;
      csr_pwrite          <= 1'b0;
      csr_paddr           <= '0;
      csr_pwdata          <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset values of both registers
      csr_access(1'b0, REG_VERTEX_COUNT, '0);
      csr_access(1'b0, REG_DIAMETER_LIMIT, '0);

      // three vertices: the only triangle is also the final one
      send_item(ACT_LOAD, EDGE_IDX_W'(0), '0);
      send_item(ACT_LOAD, EDGE_IDX_W'(1), '1);
      send_item(ACT_LOAD, EDGE_IDX_W'(2), DISTANCE_BITS_DEF'(1));
      // ranks beyond the store are dropped
      send_item(ACT_LOAD, '1, '0);
      send_item(ACT_LOAD, EDGE_IDX_W'(EDGE_COUNT), '0);
      send_item(ACT_STEP, '0, '0);
      send_item(ACT_STEP, '1, '1);

      // zero limit: all-ones weight rejected, zero weight kept
      set_config(VCOUNT_W'(3), '0);
      send_item(ACT_STEP, '0, '0);
      send_item(ACT_LOAD, EDGE_IDX_W'(1), '0);
      send_item(ACT_LOAD, EDGE_IDX_W'(2), '0);
      send_item(ACT_STEP, '0, '0);

      // count below the minimum saturates to three
      set_config('0, '1);
      send_item(ACT_STEP, '0, '0);

      // four vertices, walk up to (1,2,3) without stepping it
      set_config(VCOUNT_W'(4), '1);
      repeat (3) step_triangle(0);

      // shrinking the count leaves a stale triple: falls back to the first
      set_config(VCOUNT_W'(3), LIMIT_W'($urandom));
      step_triangle(0);

      // count above the maximum saturates to 64
      set_config('1, '1);
      repeat (2) step_triangle(0);

      // climb: hold the final triple of n, widen to n+1, walk three steps to
      // the new final triple; ends at (61,62,63) with the top edge ranks
      set_config(VCOUNT_W'(3), pick_limit());
      step_triangle(0);
      for (int k = 4; k <= MAX_VERTICES_DEF; k++) begin
         set_config(VCOUNT_W'(k), (k % 8 == 0) ? pick_limit() : walk.diameter_limit);
         repeat (3) step_triangle(20);
         if ($urandom_range(5) == 0)
            send_item(ACT_LOAD, EDGE_IDX_W'($urandom), pick_distance());
      end
      repeat (2) step_triangle(20);

      // random phases: fresh settings each time, mostly well-formed steps
      while (items_accepted < ITEM_TARGET) begin
         sel = $urandom_range(9);
         if (sel < 5) n_pick = VCOUNT_W'($urandom_range(3, 8));
         else if (sel < 7) n_pick = $urandom_range(1) ? VCOUNT_W'($urandom_range(2))
                                                     : VCOUNT_W'($urandom_range(65, 127));
         else n_pick = VCOUNT_W'($urandom_range(3, MAX_VERTICES_DEF));
         set_config(n_pick, pick_limit());
         no_idle     = ($urandom_range(4) == 0);
         phase_items = $urandom_range(30, 120);
         repeat (phase_items) begin
            sel = $urandom_range(99);
            if (sel < 80)
               step_triangle(25);
            else if (sel < 92)
               send_item(ACT_LOAD, EDGE_IDX_W'($urandom), pick_distance());
            else
               send_item(ACT_LOAD, EDGE_IDX_W'($urandom_range(EDGE_COUNT - 1)),
                         pick_distance());
         end
         no_idle = 1'b0;
      end

      wait_idle();
      if (walk.mismatches == 0 && walk.pending_triangles.size() == 0) begin
         $display("PASS rips_triangle_enumerator");
      end else begin
         $display("FAIL rips_triangle_enumerator");
      end
      $finish;
   end

endmodule
